[src/mf2d_pkg.sv]
// Shared types and constants for the minifloat to binary64 widening converter.
`default_nettype none

package mf2d_pkg;

	localparam int CODE_W     = 64;
	localparam int DBL_W      = 64;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam int EXPW_W     = 4;
	localparam int FRACW_W    = 6;

	localparam logic [EXPW_W-1:0]  EXP_BITS_RST  = 4'd8;
	localparam logic [FRACW_W-1:0] FRAC_BITS_RST = 6'd23;
	localparam logic [EXPW_W-1:0]  EXP_BITS_MIN  = 4'd2;
	localparam logic [EXPW_W-1:0]  EXP_BITS_MAX  = 4'd11;
	localparam logic [FRACW_W-1:0] FRAC_BITS_MIN = 6'd1;
	localparam logic [FRACW_W-1:0] FRAC_BITS_MAX = 6'd52;

	localparam logic [63:0] EXP_ALL   = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
	localparam logic [10:0] D_BIAS    = 11'd1023;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXP_BITS  = 8'd0,
		CFG_FRAC_BITS = 8'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CLS_ZERO = 3'd0,
		CLS_SUB  = 3'd1,
		CLS_NORM = 3'd2,
		CLS_INF  = 3'd3,
		CLS_NAN  = 3'd4
	} cls_t;

	// Unpacked operand between the field stage and the assembly stage.
	typedef struct packed {
		logic        sgn;
		cls_t        cls;
		logic [51:0] frac_al;   // fraction left-aligned to 52 bits
		logic [10:0] exp_norm;  // biased binary64 exponent for normals
		logic [10:0] exp_sub;   // biased exponent after normalizing a subnormal
		logic [5:0]  norm_sh;   // left shift that pushes the leading one out
		logic        sub_keep;  // 11-bit exponent: subnormal stays subnormal
		logic [12:0] ulp_e;     // biased ulp exponent, two's complement
	} mid_t;

endpackage

`default_nettype wire

[src/mf2d_if.sv]
// Channel interfaces: operand words, result words, configuration writes.
`default_nettype none

interface mf2d_code_if import mf2d_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code;

	modport source (output valid, output code, input ready);
	modport sink   (input valid, input code, output ready);
endinterface

interface mf2d_result_if import mf2d_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DBL_W-1:0] value_bits;
	logic [DBL_W-1:0] ulp_bits;

	modport source (output valid, output value_bits, output ulp_bits, input ready);
	modport sink   (input valid, input value_bits, input ulp_bits, output ready);
endinterface

interface mf2d_cfg_if import mf2d_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/mf2d_unpack.sv]
// Field extraction, classification and leading-one search for one source word.
`default_nettype none

module mf2d_unpack import mf2d_pkg::*; (
	input  logic [CODE_W-1:0]  code,
	input  logic [EXPW_W-1:0]  exp_bits,
	input  logic [FRACW_W-1:0] frac_bits,
	output mid_t               mid
);

	function automatic logic [5:0] lead_one(input logic [51:0] m);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 52; i++) begin
			if (m[i]) p = 6'(i);
		end
		return p;
	endfunction

	logic [EXPW_W-1:0]  w_c;
	logic [FRACW_W-1:0] t_c;
	logic [5:0]         sidx;
	logic [63:0]        shr;
	logic [10:0]        emask;
	logic [10:0]        bias;
	logic [10:0]        ex;
	logic [10:0]        eff;
	logic [51:0]        mmask;
	logic [51:0]        man;
	logic [5:0]         p;

	always_comb begin
		if (exp_bits < EXP_BITS_MIN) w_c = EXP_BITS_MIN;
		else if (exp_bits > EXP_BITS_MAX) w_c = EXP_BITS_MAX;
		else w_c = exp_bits;
		if (frac_bits < FRAC_BITS_MIN) t_c = FRAC_BITS_MIN;
		else if (frac_bits > FRAC_BITS_MAX) t_c = FRAC_BITS_MAX;
		else t_c = frac_bits;
	end

	assign sidx  = {2'b0, w_c} + t_c;
	assign shr   = code >> t_c;
	assign emask = 11'h7FF >> (EXP_BITS_MAX - w_c);
	assign bias  = 11'h3FF >> (EXP_BITS_MAX - w_c);
	assign ex    = shr[10:0] & emask;
	assign eff   = (ex == '0) ? 11'd1 : ex;
	assign mmask = 52'hF_FFFF_FFFF_FFFF >> (FRAC_BITS_MAX - t_c);
	assign man   = code[51:0] & mmask;
	assign p     = lead_one(man);

	always_comb begin
		mid.sgn      = code[sidx];
		mid.frac_al  = man << (FRAC_BITS_MAX - t_c);
		mid.exp_norm = 11'({1'b0, ex} + {1'b0, D_BIAS} - {1'b0, bias});
		// 1023 - bias - (leading zeros of the aligned fraction)
		mid.exp_sub  = 11'({1'b0, D_BIAS} + 12'd1 - {1'b0, bias} - {6'b0, t_c} + {6'b0, p});
		mid.norm_sh  = t_c - p;
		mid.sub_keep = (w_c == EXP_BITS_MAX);
		mid.ulp_e    = {2'b0, eff} + {2'b0, D_BIAS} - {2'b0, bias} - {7'b0, t_c};
		if (ex == emask) begin
			mid.cls = (man == '0) ? CLS_INF : CLS_NAN;
		end else if (ex != '0) begin
			mid.cls = CLS_NORM;
		end else begin
			mid.cls = (man == '0) ? CLS_ZERO : CLS_SUB;
		end
	end

endmodule

`default_nettype wire

[src/mf2d_pack.sv]
// Assembly of the binary64 value and ulp patterns from the unpacked fields.
`default_nettype none

module mf2d_pack import mf2d_pkg::*; (
	input  mid_t             mid,
	output logic [DBL_W-1:0] value_bits,
	output logic [DBL_W-1:0] ulp_bits
);

	logic [51:0]      frac_norm;
	logic [DBL_W-1:0] ulp_fin;
	logic [5:0]       ulp_sh;

	assign frac_norm = mid.frac_al << mid.norm_sh;
	assign ulp_sh    = 6'(mid.ulp_e + 13'd51);

	always_comb begin
		// below the normal range the ulp is a binary64 subnormal
		if (!mid.ulp_e[12] && mid.ulp_e != '0) ulp_fin = {1'b0, mid.ulp_e[10:0], 52'b0};
		else ulp_fin = 64'd1 << ulp_sh;
	end

	always_comb begin
		unique case (mid.cls)
			CLS_NAN: begin
				value_bits = {mid.sgn, QNAN_BITS[62:0]} | ({12'b0, mid.frac_al} & FRAC_MASK);
				ulp_bits   = QNAN_BITS;
			end
			CLS_INF: begin
				value_bits = {mid.sgn, EXP_ALL[62:0]};
				ulp_bits   = EXP_ALL;
			end
			CLS_NORM: begin
				value_bits = {mid.sgn, mid.exp_norm, mid.frac_al};
				ulp_bits   = ulp_fin;
			end
			CLS_SUB: begin
				if (mid.sub_keep) value_bits = {mid.sgn, 11'b0, mid.frac_al};
				else value_bits = {mid.sgn, mid.exp_sub, frac_norm};
				ulp_bits = ulp_fin;
			end
			CLS_ZERO: begin
				value_bits = {mid.sgn, 63'b0};
				ulp_bits   = ulp_fin;
			end
			default: begin
				value_bits = '0;
				ulp_bits   = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/minifloat_to_double_widen.sv]
// Top level: minifloat to binary64 widening converter with three-register pipeline.
//
//   channel   dir   payload                    notes
//   operand   in    code[63:0]                 source word, right-aligned
//   result    out   value_bits, ulp_bits       binary64 value and ulp
//   cfg       in    index[7:0], data[7:0]      0: exp_bits, 1: frac_bits
//
// One word per cycle unless the pipeline is stalled; each word passes through the
// input register, the unpacked-field register and the result register before
// result valid rises.
// Unpack (field shifts, leading-one search) and pack (normalizing shift) each
// take one register-to-register path. Reset clears stage valids and loads
// exp_bits 8, frac_bits 23. Operand ready drops only when all three stages
// hold words and the result is not taken; cfg is always ready.
`default_nettype none

module minifloat_to_double_widen import mf2d_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	mf2d_code_if.sink     operand,
	mf2d_result_if.source result,
	mf2d_cfg_if.sink      cfg
);

	logic [EXPW_W-1:0]  exp_bits_q;
	logic [FRACW_W-1:0] frac_bits_q;

	logic              v_s1, v_s2, v_s3;
	logic              en_s1, en_s2, en_s3;
	logic [CODE_W-1:0] code_s1;
	mid_t              mid_c, mid_s2;
	logic [DBL_W-1:0]  value_c, ulp_c;
	logic [DBL_W-1:0]  value_s3, ulp_s3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_bits_q  <= EXP_BITS_RST;
			frac_bits_q <= FRAC_BITS_RST;
		end else if (cfg.valid) begin
			// writes to unknown indexes are dropped
			unique case (cfg.index)
				CFG_EXP_BITS:  exp_bits_q  <= cfg.data[EXPW_W-1:0];
				CFG_FRAC_BITS: frac_bits_q <= cfg.data[FRACW_W-1:0];
				default: ;
			endcase
		end
	end

	assign en_s3 = !v_s3 || result.ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign operand.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= operand.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && operand.valid) code_s1 <= operand.code;
		if (en_s2 && v_s1) mid_s2 <= mid_c;
		if (en_s3 && v_s2) begin
			value_s3 <= value_c;
			ulp_s3   <= ulp_c;
		end
	end

	mf2d_unpack u_unpack (
		.code      (code_s1),
		.exp_bits  (exp_bits_q),
		.frac_bits (frac_bits_q),
		.mid       (mid_c)
	);

	mf2d_pack u_pack (
		.mid        (mid_s2),
		.value_bits (value_c),
		.ulp_bits   (ulp_c)
	);

	assign result.valid      = v_s3;
	assign result.value_bits = value_s3;
	assign result.ulp_bits   = ulp_s3;

`ifndef NO_ASSERTIONS
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!operand.ready |-> (v_s1 && v_s2 && v_s3 && !result.ready))
		else $error("operand stalled while pipeline has room");

	a_rose_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s3) |-> $past(v_s2))
		else $error("result word appeared without a word in the field stage");

	a_nan_ulp: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.value_bits[62:52] == 11'h7FF && result.value_bits[51:0] != '0)
		|-> (result.ulp_bits == QNAN_BITS && result.value_bits[51]))
		else $error("NaN result without quiet bit or quiet NaN ulp");

	a_finite_ulp: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.value_bits[62:52] != 11'h7FF)
		|-> (result.ulp_bits[62:52] != 11'h7FF && !result.ulp_bits[63]))
		else $error("finite value with non-finite or negative ulp");
`endif

endmodule

`default_nettype wire

[dv/widen_scoreboard_pkg.sv]
// Scoreboard for the minifloat to binary64 converter: predicts and checks result words.
package widen_scoreboard_pkg;

	import mf2d_pkg::*;

	localparam int DBL_EMIN  = -1022;
	localparam int DBL_ETINY = -1074;

	typedef struct packed {
		logic [63:0] value_bits;
		logic [63:0] ulp_bits;
	} dbl_pair_t;

	class widen_scoreboard;
		logic [EXPW_W-1:0]  exp_w_reg;
		logic [FRACW_W-1:0] frac_w_reg;
		dbl_pair_t          expected_q[$];
		int                 fails;

		function new();
			exp_w_reg  = EXP_BITS_RST;
			frac_w_reg = FRAC_BITS_RST;
			fails      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_EXP_BITS)
				exp_w_reg = data[EXPW_W-1:0];
			else if (idx == CFG_FRAC_BITS)
				frac_w_reg = data[FRACW_W-1:0];
		endfunction

		// out-of-range register values are clamped when used
		function int eff_exp_w();
			if (exp_w_reg < EXP_BITS_MIN) return int'(EXP_BITS_MIN);
			if (exp_w_reg > EXP_BITS_MAX) return int'(EXP_BITS_MAX);
			return int'(exp_w_reg);
		endfunction

		function int eff_frac_w();
			if (frac_w_reg < FRAC_BITS_MIN) return int'(FRAC_BITS_MIN);
			if (frac_w_reg > FRAC_BITS_MAX) return int'(FRAC_BITS_MAX);
			return int'(frac_w_reg);
		endfunction

		function logic [63:0] pow2_bits(int e);
			if (e >= DBL_EMIN)
				return {1'b0, 11'(e + int'(D_BIAS)), 52'd0};
			if (e < DBL_ETINY)
				return 64'd0;
			return 64'd1 << (e - DBL_ETINY);
		endfunction

		function dbl_pair_t widen(logic [63:0] code);
			int          w, t, bias, e_unb, p;
			logic [63:0] ex, man, emax;
			dbl_pair_t   r;
			w    = eff_exp_w();
			t    = eff_frac_w();
			ex   = (code >> t) & ((64'd1 << w) - 64'd1);
			man  = code & ((64'd1 << t) - 64'd1);
			emax = (64'd1 << w) - 64'd1;
			bias = (1 << (w - 1)) - 1;
			r.value_bits = {code[w + t], 63'd0};
			if (ex == emax) begin
				if (man == 64'd0) begin
					r.value_bits |= EXP_ALL;
					r.ulp_bits = EXP_ALL;
				end else begin
					r.value_bits |= QNAN_BITS | ((man << (52 - t)) & FRAC_MASK);
					r.ulp_bits = QNAN_BITS;
				end
			end else if (ex != 64'd0) begin
				e_unb = int'(ex) - bias;
				r.value_bits[62:52] = 11'(e_unb + int'(D_BIAS));
				r.value_bits |= (man << (52 - t)) & FRAC_MASK;
				r.ulp_bits = pow2_bits(e_unb - t);
			end else begin
				e_unb = 1 - bias;
				if (man != 64'd0) begin
					if (e_unb <= DBL_EMIN) begin
						// 11-bit exponent: source subnormal maps onto binary64 subnormal
						r.value_bits |= (man << (52 - t)) & FRAC_MASK;
					end else begin
						p = t - 1;
						while (p > 0 && man[p] == 1'b0)
							p--;
						r.value_bits[62:52] = 11'(e_unb - t + p + int'(D_BIAS));
						r.value_bits |= (man << (52 - p)) & FRAC_MASK;
					end
				end
				r.ulp_bits = pow2_bits(e_unb - t);
			end
			return r;
		endfunction

		function void note_code(logic [63:0] code);
			expected_q.push_back(widen(code));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void check_result(logic [63:0] value_bits, logic [63:0] ulp_bits);
			dbl_pair_t exp_r;
			if (expected_q.size() == 0) begin
				$error("unexpected word: value_bits %h ulp_bits %h", value_bits, ulp_bits);
				fails++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (value_bits !== exp_r.value_bits) begin
				$error("value_bits: expected %h, actual %h", exp_r.value_bits, value_bits);
				fails++;
			end
			if (ulp_bits !== exp_r.ulp_bits) begin
				$error("ulp_bits: expected %h, actual %h", exp_r.ulp_bits, ulp_bits);
				fails++;
			end
		endfunction
	endclass

endpackage

[dv/tb.sv]
// Testbench top for the minifloat to binary64 widening converter.
module tb;
	import mf2d_pkg::*;
	import widen_scoreboard_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int NUM_PHASES   = 14;
	localparam int RAND_PER_PH  = 67;
	localparam int SETTLE       = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 8'hA5;

	typedef enum {K_RAW, K_ZERO, K_SUB, K_NORM, K_INF, K_NAN} code_kind_t;

	// binary32 edge words under the reset format
	localparam logic [63:0] SINGLE_EDGES [14] = '{
		64'h0000_0000_0000_0000, 64'h0000_0000_8000_0000, 64'h0000_0000_0000_0001,
		64'h0000_0000_007F_FFFF, 64'h0000_0000_0040_0000, 64'h0000_0000_0080_0000,
		64'h0000_0000_7F7F_FFFF, 64'h0000_0000_3F80_0000, 64'h0000_0000_7F80_0000,
		64'h0000_0000_FF80_0000, 64'h0000_0000_7F80_0001, 64'h0000_0000_7FFF_FFFF,
		64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_A5A5_3F80_0000
	};
	// binary64 edge words with an 11/52 format
	localparam logic [63:0] DOUBLE_EDGES [7] = '{
		64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
		64'h7FEF_FFFF_FFFF_FFFF, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001,
		64'h0010_0000_0000_0000
	};
	// format register data per directed phase; later phases are random
	localparam logic [7:0] EXP_DATA  [10] = '{8'd8, 8'd11, 8'd2, 8'd11, 8'd2,
		8'd5, 8'd0, 8'hFF, 8'd12, 8'h1B};
	localparam logic [7:0] FRAC_DATA [10] = '{8'd23, 8'd52, 8'd1, 8'd1, 8'd52,
		8'd10, 8'd0, 8'hFF, 8'd53, 8'h40};

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   snk_stall_pct;
	int   cycles;

	widen_scoreboard sb;

	mf2d_code_if   operand();
	mf2d_result_if result();
	mf2d_cfg_if    cfg();

	minifloat_to_double_widen uut (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand),
		.result (result),
		.cfg    (cfg)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// result side: check accepted words, stall at random
	initial begin
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result.valid && result.ready)
				sb.check_result(result.value_bits, result.ulp_bits);
			result.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	function automatic logic [63:0] make_code(int w, int t);
		logic [63:0] c, man, ex, emax;
		code_kind_t  kind;
		int          pick;
		c    = {$urandom, $urandom};
		emax = (64'd1 << w) - 64'd1;
		man  = {$urandom, $urandom} & ((64'd1 << t) - 64'd1);
		// single set bits exercise the leading-one search
		if ($urandom_range(2) == 0)
			man = 64'd1 << $urandom_range(t - 1);
		pick = $urandom_range(99);
		if (pick < 10)      kind = K_RAW;
		else if (pick < 20) kind = K_ZERO;
		else if (pick < 40) kind = K_SUB;
		else if (pick < 70) kind = K_NORM;
		else if (pick < 80) kind = K_INF;
		else                kind = K_NAN;
		ex = 64'd0;
		case (kind)
			K_RAW:  return c;
			K_ZERO: man = 64'd0;
			K_SUB: begin
				if (man == 64'd0) man = 64'd1;
			end
			K_NORM: begin
				if ($urandom_range(3) == 0)
					ex = $urandom_range(1) ? 64'd1 : emax - 64'd1;
				else
					ex = 64'($urandom_range(int'(emax) - 1, 1));
			end
			K_INF: begin
				ex  = emax;
				man = 64'd0;
			end
			K_NAN: begin
				ex = emax;
				if (man == 64'd0) man = 64'd1 << (t - 1);
			end
		endcase
		c = (c & ~((64'd1 << (w + t + 1)) - 64'd1)) | (64'($urandom_range(1)) << (w + t))
			| (ex << t) | man;
		return c;
	endfunction

	task automatic send_code(input logic [63:0] c);
		while ($urandom_range(99) < src_idle_pct) begin
			operand.valid <= 1'b0;
			@(posedge clk);
		end
		operand.valid <= 1'b1;
		operand.code  <= c;
		do @(posedge clk); while (!operand.ready);
		sb.note_code(c);
	endtask

	// leaves valid high; the caller lowers it after the last write
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, d);
	endtask

	task automatic drain_results();
		operand.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [7:0] e_data, f_data;
		sb = new();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		arst_n        <= 1'b0;
		operand.valid <= 1'b0;
		operand.code  <= '0;
		cfg.valid     <= 1'b0;
		cfg.index     <= CFG_EXP_BITS;
		cfg.data      <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain_results();
				if (ph < 10) begin
					e_data = EXP_DATA[ph];
					f_data = FRAC_DATA[ph];
				end else begin
					e_data = 8'($urandom_range(255));
					f_data = 8'($urandom_range(255));
				end
				if (ph == 10)
					write_cfg(CFG_IDX_NONE, 8'($urandom_range(255)));
				write_cfg(CFG_EXP_BITS, e_data);
				write_cfg(CFG_FRAC_BITS, f_data);
				cfg.valid <= 1'b0;
			end
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
				default: begin src_idle_pct = 12; snk_stall_pct = 12; end
			endcase
			if (ph == 0)
				foreach (SINGLE_EDGES[i]) send_code(SINGLE_EDGES[i]);
			if (ph == 1)
				foreach (DOUBLE_EDGES[i]) send_code(DOUBLE_EDGES[i]);
			for (int n = 0; n < RAND_PER_PH; n++)
				send_code(make_code(sb.eff_exp_w(), sb.eff_frac_w()));
		end
		drain_results();

		if (sb.fails == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[minifloat_to_double_widen.f]
src/mf2d_pkg.sv
src/mf2d_if.sv
src/mf2d_unpack.sv
src/mf2d_pack.sv
src/minifloat_to_double_widen.sv
dv/widen_scoreboard_pkg.sv
dv/tb.sv
